/* sv/history_ring_with_cursor_core_defines.svh */
// Assertion macros for the history ring checker
`ifndef HISTORY_RING_WITH_CURSOR_CORE_DEFINES_SVH
`define HISTORY_RING_WITH_CURSOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HRC_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("history ring check failed");

// next-cycle implication, disabled while in reset
`define HRC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("history ring check failed");

`endif

/* sv/hrc_pkg.sv */
// Shared types and constants for the history ring with read cursor
`default_nettype none

package hrc_pkg;

	localparam int CAPACITY_DEF  = 1024;
	localparam int ITEM_BITS_DEF = 8;
	localparam int DATA_BITS     = 8;
	localparam int DIST_BITS     = 11;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_NEXT = 1'b1;

	typedef enum logic [1:0] {
		STS_APPEND    = 2'd0,
		STS_OVERWRITE = 2'd1,
		STS_NEXT_OK   = 2'd2,
		STS_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_READ = 1'b1
	} fsm_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} mem_cmd_t;

endpackage

`default_nettype wire

/* sv/hrc_ram.sv */
// Single-port window memory with registered read data
`default_nettype none

module hrc_ram #(
	parameter int DEPTH = hrc_pkg::CAPACITY_DEF,
	parameter int WIDTH = hrc_pkg::ITEM_BITS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire hrc_pkg::mem_cmd_t cmd,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

/* sv/hrc_ctrl.sv */
// Window pointers, cursor, sequencer and result register
`default_nettype none

module hrc_ctrl #(
	parameter int CAPACITY  = hrc_pkg::CAPACITY_DEF,
	parameter int ITEM_BITS = hrc_pkg::ITEM_BITS_DEF,
	localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW       = $clog2(CAPACITY + 1),
	localparam int DB       = hrc_pkg::DATA_BITS,
	localparam int DW       = hrc_pkg::DIST_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic                 op,
	input  wire logic [DB-1:0]        push_data,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output logic      [DB-1:0]        read_data,
	output logic      [DW-1:0]        distance,
	output logic                      more_items,
	output logic      [1:0]           status,
	output hrc_pkg::mem_cmd_t         mem_cmd,
	output logic      [AW-1:0]        mem_addr,
	output logic      [ITEM_BITS-1:0] mem_wdata,
	input  wire logic [ITEM_BITS-1:0] mem_rdata
);

	hrc_pkg::fsm_t    state_q, state_d;
	logic [CW-1:0]    fill_q, fill_d;
	logic [AW-1:0]    oldest_q, oldest_d;
	logic [AW-1:0]    cursor_q, cursor_d;
	logic             more_q, more_d;
	logic [CW-1:0]    dist_s1;
	logic             more_s1;
	logic             rsp_valid_q;
	logic [DB-1:0]    read_data_q;
	logic [DW-1:0]    distance_q;
	logic             more_items_q;
	hrc_pkg::status_t status_q;

	logic             accept;
	logic             full;
	logic [AW-1:0]    oldest_inc;
	logic [CW-1:0]    cursor_inc;
	logic [AW-1:0]    cursor_nxt;
	logic [CW-1:0]    dist_calc;
	logic             load;
	logic [DB-1:0]    load_data;
	logic [DW-1:0]    load_dist;
	logic             load_more;
	hrc_pkg::status_t load_status;

	assign req_ready  = (state_q == hrc_pkg::FSM_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept     = req_valid && req_ready;
	assign full       = (fill_q == CW'(CAPACITY));
	assign oldest_inc = (oldest_q == AW'(CAPACITY - 1)) ? '0 : oldest_q + AW'(1);
	assign cursor_inc = CW'(cursor_q) + CW'(1);
	assign cursor_nxt = (cursor_inc == fill_q) ? '0 : AW'(cursor_inc);
	assign dist_calc  = (oldest_q > cursor_q) ? CW'(oldest_q) - CW'(cursor_q)
	                                          : fill_q - CW'(cursor_q) + CW'(oldest_q);
	assign mem_wdata  = ITEM_BITS'(push_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hrc_pkg::FSM_IDLE;
			fill_q   <= '0;
			oldest_q <= '0;
			cursor_q <= '0;
			more_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			oldest_q <= oldest_d;
			cursor_q <= cursor_d;
			more_q   <= more_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		oldest_d    = oldest_q;
		cursor_d    = cursor_q;
		more_d      = more_q;
		mem_cmd     = '0;
		mem_addr    = cursor_q;
		load        = 1'b0;
		load_data   = '0;
		load_dist   = '0;
		load_more   = 1'b0;
		load_status = hrc_pkg::STS_EMPTY;
		case (state_q)
			hrc_pkg::FSM_IDLE: begin
				if (accept) begin
					if (op == hrc_pkg::OP_PUSH) begin
						mem_cmd.wr = 1'b1;
						more_d     = 1'b1;
						load       = 1'b1;
						load_more  = 1'b1;
						if (!full) begin
							mem_addr    = AW'(fill_q);
							fill_d      = fill_q + CW'(1);
							cursor_d    = '0;
							load_status = hrc_pkg::STS_APPEND;
						end else begin
							mem_addr    = oldest_q;
							oldest_d    = oldest_inc;
							cursor_d    = oldest_inc;
							load_status = hrc_pkg::STS_OVERWRITE;
						end
					end else if (!more_q || fill_q == '0) begin
						load        = 1'b1;
						load_status = hrc_pkg::STS_EMPTY;
					end else begin
						mem_cmd.rd = 1'b1;
						mem_addr   = cursor_q;
						cursor_d   = cursor_nxt;
						more_d     = (cursor_nxt != oldest_q);
						state_d    = hrc_pkg::FSM_READ;
					end
				end
			end
			hrc_pkg::FSM_READ: begin
				load        = 1'b1;
				load_data   = DB'(mem_rdata);
				load_dist   = DW'(dist_s1);
				load_more   = more_s1;
				load_status = hrc_pkg::STS_NEXT_OK;
				state_d     = hrc_pkg::FSM_IDLE;
			end
			default: begin
				state_d = hrc_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_cmd.rd) begin
			dist_s1 <= dist_calc;
			more_s1 <= more_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			read_data_q  <= load_data;
			distance_q   <= load_dist;
			more_items_q <= load_more;
			status_q     <= load_status;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_data  = read_data_q;
	assign distance   = distance_q;
	assign more_items = more_items_q;
	assign status     = status_q;

endmodule

`default_nettype wire

/* sv/history_ring_with_cursor_core.sv */
// History ring with read cursor: top level
//
// Sliding history window of CAPACITY items of ITEM_BITS bits, kept in one
// synchronous memory. A push word (op 0) stores push_data, appending until
// the window is full and then overwriting the oldest item; it rewinds the
// read cursor to the oldest item. A next word (op 1) returns the item at the
// cursor with its distance back from the newest item (newest is 1) and
// advances the cursor; with nothing left it answers status 3. Every request
// word gives exactly one response word. A push or an empty next loads the
// response register directly; a successful next loads it from registered
// memory data in READ. Requests are taken in IDLE if the response register
// is empty or being drained. No clearing pass follows reset.
`default_nettype none

module history_ring_with_cursor_core #(
	parameter int CAPACITY  = hrc_pkg::CAPACITY_DEF,
	parameter int ITEM_BITS = hrc_pkg::ITEM_BITS_DEF,
	localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic                          op,
	input  wire logic [hrc_pkg::DATA_BITS-1:0] push_data,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic      [hrc_pkg::DATA_BITS-1:0] read_data,
	output logic      [hrc_pkg::DIST_BITS-1:0] distance,
	output logic                               more_items,
	output logic      [1:0]                    status
);

	hrc_pkg::mem_cmd_t      mem_cmd;
	logic [AW-1:0]          mem_addr;
	logic [ITEM_BITS-1:0]   mem_wdata;
	logic [ITEM_BITS-1:0]   mem_rdata;

	hrc_ctrl #(
		.CAPACITY  (CAPACITY),
		.ITEM_BITS (ITEM_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.op         (op),
		.push_data  (push_data),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.read_data  (read_data),
		.distance   (distance),
		.more_items (more_items),
		.status     (status),
		.mem_cmd    (mem_cmd),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata)
	);

	hrc_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ITEM_BITS)
	) u_ram (
		.clk   (clk),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

/* sv/hrc_checker.sv */
// Port-level checks for the history ring, bound to the top level
`default_nettype none

`include "history_ring_with_cursor_core_defines.svh"

module hrc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          op,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [hrc_pkg::DATA_BITS-1:0] read_data,
	input wire logic [hrc_pkg::DIST_BITS-1:0] distance,
	input wire logic                          more_items,
	input wire logic [1:0]                    status
);

	logic push_rsp;
	logic push_acc;

	assign push_rsp = rsp_valid && (status == hrc_pkg::STS_APPEND ||
	                                status == hrc_pkg::STS_OVERWRITE);
	assign push_acc = req_valid && req_ready && (op == hrc_pkg::OP_PUSH);

	`HRC_ASSERT_SAME(a_push_rsp_form, clk, arst_n, push_rsp, read_data == '0 && distance == '0 && more_items)
	`HRC_ASSERT_SAME(a_empty_rsp_form, clk, arst_n, rsp_valid && status == hrc_pkg::STS_EMPTY, read_data == '0 && distance == '0 && !more_items)
	`HRC_ASSERT_NEXT(a_push_answers_next, clk, arst_n, push_acc, push_rsp)
	`HRC_ASSERT_NEXT(a_rsp_holds, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(read_data) && $stable(distance))

endmodule

bind history_ring_with_cursor_core hrc_checker u_hrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_ready  (req_ready),
	.op         (op),
	.rsp_valid  (rsp_valid),
	.rsp_ready  (rsp_ready),
	.read_data  (read_data),
	.distance   (distance),
	.more_items (more_items),
	.status     (status)
);

`default_nettype wire

/* tb/history_ring_with_cursor_core_tb.sv */
// Self-checking testbench for the history ring with read cursor
`timescale 1ns / 1ps

module history_ring_with_cursor_core_tb;

	localparam int CAP = hrc_pkg::CAPACITY_DEF;

	typedef struct {
		logic [hrc_pkg::DATA_BITS-1:0] data;
		logic [hrc_pkg::DIST_BITS-1:0] span;
		logic                          more;
		hrc_pkg::status_t              sts;
	} rsp_word_t;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          req_valid = 1'b0;
	logic                          op        = hrc_pkg::OP_PUSH;
	logic [hrc_pkg::DATA_BITS-1:0] push_data = '0;
	logic                          rsp_ready = 1'b0;
	logic                          req_ready;
	logic                          rsp_valid;
	logic [hrc_pkg::DATA_BITS-1:0] read_data;
	logic [hrc_pkg::DIST_BITS-1:0] distance;
	logic                          more_items;
	logic [1:0]                    status;

	history_ring_with_cursor_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.op         (op),
		.push_data  (push_data),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.read_data  (read_data),
		.distance   (distance),
		.more_items (more_items),
		.status     (status)
	);

	// window predictor state
	logic [hrc_pkg::DATA_BITS-1:0] hist_mem [CAP];
	int unsigned                   hist_fill   = 0;
	int unsigned                   hist_oldest = 0;
	int unsigned                   hist_cursor = 0;
	bit                            hist_more   = 1'b0;

	rsp_word_t expected_words [$];
	rsp_word_t exp_w;
	int        mismatch_count = 0;
	int        append_cnt     = 0;
	int        overwrite_cnt  = 0;
	int        read_cnt       = 0;
	int        empty_cnt      = 0;
	bit        steady         = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic rsp_word_t predict_window(input logic o,
		input logic [hrc_pkg::DATA_BITS-1:0] d);
		rsp_word_t   w;
		int unsigned cur;
		w.data = '0;
		w.span = '0;
		w.more = 1'b0;
		w.sts  = hrc_pkg::STS_EMPTY;
		if (o == hrc_pkg::OP_PUSH) begin
			hist_more = 1'b1;
			if (hist_fill < CAP) begin
				hist_mem[hist_fill] = d;
				hist_fill++;
				hist_cursor = 0;
				w.sts = hrc_pkg::STS_APPEND;
			end else begin
				hist_mem[hist_oldest] = d;
				hist_oldest = (hist_oldest + 1) % CAP;
				hist_cursor = hist_oldest;
				w.sts = hrc_pkg::STS_OVERWRITE;
			end
			w.more = 1'b1;
		end else if (hist_more && hist_fill != 0) begin
			cur = hist_cursor % hist_fill;
			w.data = hist_mem[cur];
			w.span = (hist_oldest > cur) ? hrc_pkg::DIST_BITS'(hist_oldest - cur)
				: hrc_pkg::DIST_BITS'(hist_fill - (cur - hist_oldest));
			hist_cursor = (cur + 1) % hist_fill;
			if (hist_cursor == hist_oldest)
				hist_more = 1'b0;
			w.more = hist_more;
			w.sts  = hrc_pkg::STS_NEXT_OK;
		end
		return w;
	endfunction

	function automatic void check_field(input string name,
		input logic [hrc_pkg::DIST_BITS-1:0] want,
		input logic [hrc_pkg::DIST_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_ready <= steady || ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual data %0d dist %0d more %0b status %0d",
					$time, read_data, distance, more_items, status);
				mismatch_count++;
			end else begin
				exp_w = expected_words.pop_front();
				check_field("read_data", hrc_pkg::DIST_BITS'(exp_w.data),
					hrc_pkg::DIST_BITS'(read_data));
				check_field("distance", exp_w.span, distance);
				check_field("more_items", hrc_pkg::DIST_BITS'(exp_w.more),
					hrc_pkg::DIST_BITS'(more_items));
				check_field("status", hrc_pkg::DIST_BITS'(exp_w.sts),
					hrc_pkg::DIST_BITS'(status));
				case (exp_w.sts)
					hrc_pkg::STS_APPEND:    append_cnt++;
					hrc_pkg::STS_OVERWRITE: overwrite_cnt++;
					hrc_pkg::STS_NEXT_OK:   read_cnt++;
					default:                empty_cnt++;
				endcase
			end
		end
	end

	task automatic send_word(input logic o, input logic [hrc_pkg::DATA_BITS-1:0] d);
		if (!steady && $urandom_range(99) < 7) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req_valid <= 1'b1;
		op        <= o;
		push_data <= d;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		expected_words.push_back(predict_window(o, d));
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	task automatic test_reset_reads();
		repeat (2) send_word(hrc_pkg::OP_NEXT, 8'($urandom));
	endtask

	task automatic test_corner_words();
		send_word(hrc_pkg::OP_PUSH, 8'h00);
		send_word(hrc_pkg::OP_PUSH, 8'hFF);
		send_word(hrc_pkg::OP_PUSH, 8'h5A);
		send_word(hrc_pkg::OP_PUSH, 8'hA5);
		repeat (2) send_word(hrc_pkg::OP_NEXT, 8'hFF);
		// rewind cursor to the oldest word
		send_word(hrc_pkg::OP_PUSH, 8'h3C);
		repeat (7) send_word(hrc_pkg::OP_NEXT, 8'($urandom));
	endtask

	task automatic test_fill_window();
		int burst;
		while (hist_fill < CAP) begin
			if ($urandom_range(99) < 3) begin
				burst = $urandom_range(8, 1);
				repeat (burst) send_word(hrc_pkg::OP_NEXT, 8'($urandom));
			end else begin
				send_word(hrc_pkg::OP_PUSH, 8'($urandom));
			end
		end
	endtask

	task automatic test_overwrite_sweep();
		int n;
		n = $urandom_range(40, 1);
		repeat (n) send_word(hrc_pkg::OP_PUSH, 8'($urandom));
		wait_for_results();
		steady = 1'b1;
		n = 0;
		while (hist_more) begin
			if (n == 512)
				steady = 1'b0;
			send_word(hrc_pkg::OP_NEXT, 8'($urandom));
			n++;
		end
		steady = 1'b0;
		repeat (2) send_word(hrc_pkg::OP_NEXT, 8'($urandom));
	endtask

	task automatic test_mixed_traffic();
		repeat (80) begin
			if ($urandom_range(1))
				send_word(hrc_pkg::OP_PUSH, 8'($urandom));
			else
				send_word(hrc_pkg::OP_NEXT, 8'($urandom));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_reads();
		test_corner_words();
		test_fill_window();
		test_overwrite_sweep();
		test_mixed_traffic();
		wait_for_results();
		repeat (12) @(posedge clk);
		$display("Run covered %0d appends, %0d overwrites, %0d reads and %0d empty reads,",
			append_cnt, overwrite_cnt, read_cnt, empty_cnt);
		$display("including a full-window sweep past the wrap; %0d mismatches.", mismatch_count);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
